// ===== hdl/ksat_pkg.sv =====
// shared types and codes of the keyed statistics table
`default_nettype none

package ksat_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 22;
    localparam int DELTA_W  = 32;
    localparam int TOTAL_W  = 64;
    localparam int TICK_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // request as it enters the chain
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [DELTA_W-1:0] minor;
        logic [DELTA_W-1:0] major;
        logic [DELTA_W-1:0] cpu;
        logic [TICK_W-1:0]  stamp;
    } t_req;

    // data picked up from the matching cell
    typedef struct packed {
        logic [TOTAL_W-1:0] minor;
        logic [TOTAL_W-1:0] major;
        logic [TOTAL_W-1:0] cpu;
        logic [TICK_W-1:0]  start;
        logic [TICK_W-1:0]  last;
    } t_res;

    // token handed from cell to cell
    typedef struct packed {
        logic vld;
        logic done;
        t_req req;
        t_res res;
    } t_tok;

endpackage

`default_nettype wire

// ===== hdl/ksat_cell.sv =====
// one table slot: holds an entry and acts on the token passing by
`default_nettype none

module ksat_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire ksat_pkg::t_tok i_tok,
    output ksat_pkg::t_tok     o_tok
);

    logic                            r_valid;
    logic [ksat_pkg::KEY_W-1:0]      r_key;
    logic [ksat_pkg::TOTAL_W-1:0]    r_minor;
    logic [ksat_pkg::TOTAL_W-1:0]    r_major;
    logic [ksat_pkg::TOTAL_W-1:0]    r_cpu;
    logic [ksat_pkg::TICK_W-1:0]     r_start;
    logic [ksat_pkg::TICK_W-1:0]     r_last;
    logic                            r_tok_vld;
    logic                            r_tok_done;
    ksat_pkg::t_req                  r_tok_req;
    ksat_pkg::t_res                  r_tok_res;

    logic                            n_valid;
    logic [ksat_pkg::KEY_W-1:0]      n_key;
    logic [ksat_pkg::TOTAL_W-1:0]    n_minor;
    logic [ksat_pkg::TOTAL_W-1:0]    n_major;
    logic [ksat_pkg::TOTAL_W-1:0]    n_cpu;
    logic [ksat_pkg::TICK_W-1:0]     n_start;
    logic [ksat_pkg::TICK_W-1:0]     n_last;
    ksat_pkg::t_tok                  n_tok;

    logic hit_free;
    logic hit_key;

    always_comb begin
        hit_free = i_tok.vld && !i_tok.done && (i_tok.req.op == ksat_pkg::OP_ADD) && !r_valid;
        hit_key  = i_tok.vld && !i_tok.done && (i_tok.req.op != ksat_pkg::OP_ADD) && r_valid
                   && (r_key == i_tok.req.key);

        n_valid = r_valid;
        n_key   = r_key;
        n_minor = r_minor;
        n_major = r_major;
        n_cpu   = r_cpu;
        n_start = r_start;
        n_last  = r_last;
        n_tok   = i_tok;

        if (hit_free) begin
            n_valid = 1'b1;
            n_key   = i_tok.req.key;
            n_minor = {32'd0, i_tok.req.minor};
            n_major = {32'd0, i_tok.req.major};
            n_cpu   = {32'd0, i_tok.req.cpu};
            n_start = i_tok.req.stamp;
            n_last  = i_tok.req.stamp;
        end else if (hit_key) begin
            case (i_tok.req.op)
                ksat_pkg::OP_UPDATE: begin
                    n_minor = r_minor + {32'd0, i_tok.req.minor};
                    n_major = r_major + {32'd0, i_tok.req.major};
                    n_cpu   = r_cpu + {32'd0, i_tok.req.cpu};
                    n_last  = i_tok.req.stamp;
                end
                ksat_pkg::OP_DELETE: begin
                    n_valid = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (hit_free || hit_key) begin
            n_tok.done = 1'b1;
            // a deleted entry reports zeros, which the token already carries
            if (i_tok.req.op != ksat_pkg::OP_DELETE) begin
                n_tok.res.minor = n_minor;
                n_tok.res.major = n_major;
                n_tok.res.cpu   = n_cpu;
                n_tok.res.start = n_start;
                n_tok.res.last  = n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok_vld <= 1'b0;
        end else if (i_en) begin
            r_valid   <= n_valid;
            r_tok_vld <= n_tok.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_key      <= n_key;
            r_minor    <= n_minor;
            r_major    <= n_major;
            r_cpu      <= n_cpu;
            r_start    <= n_start;
            r_last     <= n_last;
            r_tok_done <= n_tok.done;
            r_tok_req  <= n_tok.req;
            r_tok_res  <= n_tok.res;
        end
    end

    assign o_tok = {r_tok_vld, r_tok_done, r_tok_req, r_tok_res};

endmodule

`default_nettype wire

// ===== hdl/keyed_stats_accumulator_table_top.sv =====
// top level of the keyed statistics table: a chain of slot cells
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    i_op i_proc_id i_minor_faults i_major_faults
//                                            i_cpu_time i_stamp
//  result    out        o_valid / i_ready    o_status o_minor_total o_major_total
//                                            o_cpu_total o_start_time o_last_time
//                                            o_entry_count
//
// a request transaction walks the cell chain one slot per cycle while the chain is not
// stalled, and its result is then loaded into the output register; one request is in the
// chain at a time, and the next is taken in the cycle after the result is loaded
// reset clears every slot valid bit, the entry count and all handshake state
// a result not taken freezes the whole chain once the next token reaches its end
`default_nettype none

module keyed_stats_accumulator_table_top #(
    parameter int ENTRIES = ksat_pkg::ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [ksat_pkg::OP_W-1:0]       i_op,
    input  wire logic [ksat_pkg::KEY_W-1:0]      i_proc_id,
    input  wire logic [ksat_pkg::DELTA_W-1:0]    i_minor_faults,
    input  wire logic [ksat_pkg::DELTA_W-1:0]    i_major_faults,
    input  wire logic [ksat_pkg::DELTA_W-1:0]    i_cpu_time,
    input  wire logic [ksat_pkg::TICK_W-1:0]     i_stamp,

    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [ksat_pkg::STATUS_W-1:0]        o_status,
    output logic [ksat_pkg::TOTAL_W-1:0]         o_minor_total,
    output logic [ksat_pkg::TOTAL_W-1:0]         o_major_total,
    output logic [ksat_pkg::TOTAL_W-1:0]         o_cpu_total,
    output logic [ksat_pkg::TICK_W-1:0]          o_start_time,
    output logic [ksat_pkg::TICK_W-1:0]          o_last_time,
    output logic [ksat_pkg::COUNT_W-1:0]         o_entry_count
);

    // wide enough to hold ENTRIES itself
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // chain links: link[i] feeds cell i, link[ENTRIES] leaves the last cell
    ksat_pkg::t_tok link [ENTRIES+1];

    logic           chain_en;
    logic           accept;
    logic           load_out;
    ksat_pkg::t_tok tail;

    logic                            r_busy;
    logic                            n_busy;
    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                n_count;
    logic                            r_out_vld;
    logic                            n_out_vld;
    logic [ksat_pkg::STATUS_W-1:0]   r_status;
    logic [ksat_pkg::STATUS_W-1:0]   n_status;
    ksat_pkg::t_res                  r_res;

    assign accept = i_valid && o_ready;
    assign tail   = link[ENTRIES];

    // chain stalls only while its finished token cannot move into the output register
    assign chain_en = !(tail.vld && r_out_vld && !i_ready);
    assign load_out = tail.vld && chain_en;

    // new request enters cell 0 in its accept cycle
    always_comb begin
        link[0].vld       = accept;
        link[0].done      = 1'b0;
        link[0].req.op    = i_op;
        link[0].req.key   = i_proc_id;
        link[0].req.minor = i_minor_faults;
        link[0].req.major = i_major_faults;
        link[0].req.cpu   = i_cpu_time;
        link[0].req.stamp = i_stamp;
        link[0].res       = '0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ksat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (chain_en),
            .i_tok   (link[g]),
            .o_tok   (link[g+1])
        );
    end

    // status comes from whether some cell claimed the token
    always_comb begin
        if (tail.done) begin
            n_status = ksat_pkg::ST_OK;
        end else if (tail.req.op == ksat_pkg::OP_ADD) begin
            n_status = ksat_pkg::ST_FULL;
        end else begin
            n_status = ksat_pkg::ST_NOT_FOUND;
        end
    end

    // entry count follows successful adds and deletes as they leave the chain
    always_comb begin
        n_count = r_count;
        if (load_out && tail.done) begin
            if (tail.req.op == ksat_pkg::OP_ADD) begin
                n_count = r_count + CNT_W'(1);
            end else if (tail.req.op == ksat_pkg::OP_DELETE) begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (accept) begin
            n_busy = 1'b1;
        end else if (load_out) begin
            n_busy = 1'b0;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (load_out) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status <= n_status;
            r_res    <= tail.res;
        end
    end

    assign o_ready       = !r_busy;
    assign o_valid       = r_out_vld;
    assign o_status      = r_status;
    assign o_minor_total = r_res.minor;
    assign o_major_total = r_res.major;
    assign o_cpu_total   = r_res.cpu;
    assign o_start_time  = r_res.start;
    assign o_last_time   = r_res.last;
    // count is loaded together with the result; shown masked to the port width
    assign o_entry_count = ksat_pkg::COUNT_W'(r_count);

endmodule

`default_nettype wire
